### hdl/plc_pkg.sv
// Shared constants and types for the piecewise linear curve block.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package plc_pkg;

  localparam int MaxKnots      = 16;
  localparam int ValueBits     = 16;
  localparam int SlopeFracBits = 16;

  localparam int IdxBits    = 4;
  localparam int CountBits  = 5;
  localparam int MagBits    = ValueBits + SlopeFracBits;
  localparam int SlopeBits  = MagBits + 1;
  localparam int ProdBits   = MagBits + ValueBits;
  localparam int TotalBits  = ProdBits + 2;
  localparam int DivCntBits = $clog2(MagBits);

  localparam logic [CountBits-1:0] CountReset = CountBits'(2);
  localparam logic [CountBits-1:0] CountMin   = CountBits'(2);
  localparam logic [CountBits-1:0] CountMax   = CountBits'(MaxKnots);

  typedef enum logic [0:0] {
    OpEval = 1'b0,
    OpLoad = 1'b1
  } opcode_e;

  // Query beat as it travels down the knot chain, with the best segment so far.
  typedef struct packed {
    logic [ValueBits-1:0] qx;
    logic [ValueBits-1:0] x;
    logic [ValueBits-1:0] y;
    logic [SlopeBits-1:0] slope;
  } tok_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic knot_we;
    logic slope_we;
    logic active;
    logic first;
  } cell_ctl_t;

endpackage

`default_nettype wire

### hdl/piecewise_linear_curve.sv
// Piecewise linear curve: an evaluate beat walks a chain of MaxKnots knot cells, one
// cell a cycle while the pipe is not held, then three arithmetic stages. Evaluate
// beats stream in at one a cycle unless a held output, the divider or a count write
// stops the input. A load beat waits for the chain to empty and writes its knot at
// once. For any knot but the first it then runs the bit-serial slope divider, during
// which no beat is taken. A knot count write waits for the chain to empty and goes
// ahead of a waiting input beat. The output register lets the chain keep moving while
// it is free or being emptied.
// Depends on plc_pkg, plc_cell, plc_div and plc_eval.
`default_nettype none

module piecewise_linear_curve (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [plc_pkg::IdxBits-1:0]   knot_index_i,
  input  logic [plc_pkg::ValueBits-1:0] knot_x_i,
  input  logic [plc_pkg::ValueBits-1:0] knot_y_i,
  input  logic [plc_pkg::ValueBits-1:0] query_x_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [plc_pkg::ValueBits-1:0] mapped_y_o,
  output logic                          clipped_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [plc_pkg::CountBits-1:0] knot_count_i
);
  import plc_pkg::*;

  logic [CountBits-1:0] count_q;
  logic [CountBits-1:0] n_eff;
  logic [IdxBits-1:0]   tgt_q;

  logic adv, in_fire, load_fire, eval_fire, load_ok, cfg_fire;
  logic chain_busy;
  logic div_busy, div_done, div_start;
  logic [SlopeBits-1:0] div_slope;
  logic [IdxBits-1:0]   prev_idx;

  cell_ctl_t            ctl   [MaxKnots];
  logic                 vld   [MaxKnots+1];
  tok_t                 tok   [MaxKnots+1];
  logic [ValueBits-1:0] cx    [MaxKnots];
  logic [ValueBits-1:0] cy    [MaxKnots];
  logic [MaxKnots-1:0]  vld_vec;

  // Hold a count write until no query is left in the chain.
  assign cfg_ready_o = !chain_busy;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (cfg_fire) begin
      count_q <= knot_count_i;
    end
  end

  always_comb begin
    if (count_q < CountMin) begin
      n_eff = CountMin;
    end else if (count_q > CountMax) begin
      n_eff = CountMax;
    end else begin
      n_eff = count_q;
    end
  end

  // Hold the whole pipe while the output register is full and not being taken.
  assign adv        = !out_valid_o || out_ready_i;
  assign chain_busy = |vld_vec;
  assign in_ready_o = adv && !div_busy && !cfg_fire &&
                      ((opcode_i != OpLoad) || !chain_busy);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_fire  = in_fire && (opcode_i == OpLoad);
  assign eval_fire  = in_fire && (opcode_i == OpEval);
  assign load_ok    = load_fire && ({1'b0, knot_index_i} < (IdxBits + 1)'(MaxKnots));
  assign div_start  = load_ok && (knot_index_i != '0);
  assign prev_idx   = knot_index_i - 1'b1;

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      tgt_q <= knot_index_i;
    end
  end

  plc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .x0_i    (cx[prev_idx]),
    .y0_i    (cy[prev_idx]),
    .x1_i    (knot_x_i),
    .y1_i    (knot_y_i),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .slope_o (div_slope)
  );

  assign vld[0]       = eval_fire;
  assign tok[0].qx    = query_x_i;
  assign tok[0].x     = '0;
  assign tok[0].y     = '0;
  assign tok[0].slope = '0;

  for (genvar i = 0; i < MaxKnots; i++) begin : g_chain
    // A slope lands in the cell where its segment starts.
    assign ctl[i].knot_we  = load_ok && (knot_index_i == IdxBits'(i));
    assign ctl[i].slope_we = div_done && ((tgt_q - 1'b1) == IdxBits'(i));
    assign ctl[i].active   = {1'b0, n_eff} >= (CountBits + 1)'(i + 2);
    assign ctl[i].first    = (i == 0);
    assign vld_vec[i]      = vld[i+1];

    plc_cell u_knot (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .ctl_i    (ctl[i]),
      .knot_x_i (knot_x_i),
      .knot_y_i (knot_y_i),
      .slope_i  (div_slope),
      .valid_i  (vld[i]),
      .tok_i    (tok[i]),
      .valid_o  (vld[i+1]),
      .tok_o    (tok[i+1]),
      .x_o      (cx[i]),
      .y_o      (cy[i])
    );
  end

  plc_eval u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (vld[MaxKnots]),
    .tok_i      (tok[MaxKnots]),
    .valid_o    (out_valid_o),
    .mapped_y_o (mapped_y_o),
    .clipped_o  (clipped_o)
  );

`ifndef ASSERT_OFF
  a_load_on_empty_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |-> !chain_busy)
    else $error("load beat taken while queries were in the chain");

  a_div_excludes_queries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !chain_busy)
    else $error("query in the chain while a slope was being computed");

  a_clip_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |-> (mapped_y_o == '0 || mapped_y_o == '1))
    else $error("clipped result not at a rail");
`endif

endmodule

`default_nettype wire

### hdl/plc_div.sv
// Bit-serial restoring divider for segment slopes, one quotient bit per cycle.
// Depends on plc_pkg.
`default_nettype none

module plc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [plc_pkg::ValueBits-1:0] x0_i,
  input  logic [plc_pkg::ValueBits-1:0] y0_i,
  input  logic [plc_pkg::ValueBits-1:0] x1_i,
  input  logic [plc_pkg::ValueBits-1:0] y1_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [plc_pkg::SlopeBits-1:0] slope_o
);
  import plc_pkg::*;

  typedef enum logic [1:0] {
    DivIdle,
    DivRun,
    DivDone
  } div_state_e;

  div_state_e            state_q;
  logic [DivCntBits-1:0] cnt_q;
  logic [ValueBits-1:0]  rem_q;
  logic [MagBits-1:0]    dvd_q;
  logic [ValueBits-1:0]  dx_q;
  logic                  neg_q;
  logic                  zero_q;

  logic                 dy_neg, dx_neg;
  logic [ValueBits-1:0] dy_mag, dx_mag;
  logic [ValueBits:0]   shifted;
  logic                 ge;
  logic [ValueBits:0]   rem_d;
  logic [SlopeBits-1:0] quot_ext;

  always_comb begin
    dy_neg  = y1_i < y0_i;
    dx_neg  = x1_i < x0_i;
    dy_mag  = dy_neg ? (y0_i - y1_i) : (y1_i - y0_i);
    dx_mag  = dx_neg ? (x0_i - x1_i) : (x1_i - x0_i);
    shifted = {rem_q, dvd_q[MagBits-1]};
    ge      = shifted >= {1'b0, dx_q};
    rem_d   = ge ? (shifted - {1'b0, dx_q}) : shifted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DivIdle;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        DivIdle: begin
          if (start_i) begin
            state_q <= DivRun;
            cnt_q   <= '0;
          end
        end
        DivRun: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivCntBits'(MagBits - 1)) begin
            state_q <= DivDone;
          end
        end
        DivDone: begin
          state_q <= DivIdle;
        end
        default: begin
          state_q <= DivIdle;
        end
      endcase
    end
  end

  // Datapath: the dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (state_q == DivIdle && start_i) begin
      rem_q  <= '0;
      dvd_q  <= {dy_mag, {SlopeFracBits{1'b0}}};
      dx_q   <= dx_mag;
      neg_q  <= dy_neg != dx_neg;
      zero_q <= dx_mag == '0;
    end else if (state_q == DivRun) begin
      rem_q <= rem_d[ValueBits-1:0];
      dvd_q <= {dvd_q[MagBits-2:0], ge};
    end
  end

  always_comb begin
    quot_ext = {1'b0, dvd_q};
    if (zero_q) begin
      slope_o = '0;
    end else if (neg_q) begin
      slope_o = ~quot_ext + 1'b1;
    end else begin
      slope_o = quot_ext;
    end
  end

  assign busy_o = state_q != DivIdle;
  assign done_o = state_q == DivDone;

endmodule

`default_nettype wire

### hdl/plc_cell.sv
// One knot of the curve: holds x, y and the slope of the segment that starts here,
// and passes a query beat on to its neighbour. Depends on plc_pkg.
`default_nettype none

module plc_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  plc_pkg::cell_ctl_t            ctl_i,
  input  logic [plc_pkg::ValueBits-1:0] knot_x_i,
  input  logic [plc_pkg::ValueBits-1:0] knot_y_i,
  input  logic [plc_pkg::SlopeBits-1:0] slope_i,
  input  logic                          valid_i,
  input  plc_pkg::tok_t                 tok_i,
  output logic                          valid_o,
  output plc_pkg::tok_t                 tok_o,
  output logic [plc_pkg::ValueBits-1:0] x_o,
  output logic [plc_pkg::ValueBits-1:0] y_o
);
  import plc_pkg::*;

  logic [ValueBits-1:0] x_q, y_q;
  logic [SlopeBits-1:0] slope_q;
  logic                 valid_q;
  tok_t                 tok_q;
  logic                 take;

  // The last qualifying knot wins, so a later cell simply overrides the candidate.
  assign take = ctl_i.active && (ctl_i.first || (x_q <= tok_i.qx));

  always_ff @(posedge clk_i) begin
    if (ctl_i.knot_we) begin
      x_q <= knot_x_i;
      y_q <= knot_y_i;
    end
    if (ctl_i.slope_we) begin
      slope_q <= slope_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q.qx    <= tok_i.qx;
      tok_q.x     <= take ? x_q : tok_i.x;
      tok_q.y     <= take ? y_q : tok_i.y;
      tok_q.slope <= take ? slope_q : tok_i.slope;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;
  assign x_o     = x_q;
  assign y_o     = y_q;

endmodule

`default_nettype wire

### hdl/plc_eval.sv
// Interpolation back end: magnitudes, product, rounding and saturation,
// ending in the output register. Depends on plc_pkg.
`default_nettype none

module plc_eval (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  plc_pkg::tok_t                 tok_i,
  output logic                          valid_o,
  output logic [plc_pkg::ValueBits-1:0] mapped_y_o,
  output logic                          clipped_o
);
  import plc_pkg::*;

  localparam logic [TotalBits-1:0] RoundHalf = TotalBits'(1) << (SlopeFracBits - 1);

  logic                 va_q, vb_q, vo_q;
  logic [MagBits-1:0]   mag_s_q;
  logic [ValueBits-1:0] mag_d_q;
  logic                 pneg_a_q, pneg_b_q;
  logic [ValueBits-1:0] ya_q, yb_q;
  logic [ProdBits-1:0]  prod_q;
  logic [ValueBits-1:0] mapped_q;
  logic                 clip_q;

  logic                 s_neg, d_neg;
  logic [SlopeBits-1:0] slope_neg;
  logic [MagBits-1:0]   mag_s;
  logic [ValueBits-1:0] mag_d;
  logic [TotalBits-1:0] base_e, prod_e, total;
  logic                 over;
  logic [ValueBits-1:0] mapped_d;
  logic                 clip_d;

  always_comb begin
    s_neg     = tok_i.slope[SlopeBits-1];
    slope_neg = ~tok_i.slope + 1'b1;
    mag_s     = s_neg ? slope_neg[MagBits-1:0] : tok_i.slope[MagBits-1:0];
    d_neg     = tok_i.qx < tok_i.x;
    mag_d     = d_neg ? (tok_i.x - tok_i.qx) : (tok_i.qx - tok_i.x);
  end

  always_comb begin
    base_e = {{(TotalBits - MagBits){1'b0}}, yb_q, {SlopeFracBits{1'b0}}};
    prod_e = {{(TotalBits - ProdBits){1'b0}}, prod_q};
    total  = base_e + (pneg_b_q ? (~prod_e + 1'b1) : prod_e) + RoundHalf;
    over   = |total[TotalBits-2:MagBits];
    if (total[TotalBits-1]) begin
      mapped_d = '0;
      clip_d   = 1'b1;
    end else if (over) begin
      mapped_d = '1;
      clip_d   = 1'b1;
    end else begin
      mapped_d = total[MagBits-1:SlopeFracBits];
      clip_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vo_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mag_s_q  <= mag_s;
      mag_d_q  <= mag_d;
      pneg_a_q <= s_neg != d_neg;
      ya_q     <= tok_i.y;
      prod_q   <= {{ValueBits{1'b0}}, mag_s_q} * {{MagBits{1'b0}}, mag_d_q};
      pneg_b_q <= pneg_a_q;
      yb_q     <= ya_q;
      mapped_q <= mapped_d;
      clip_q   <= clip_d;
    end
  end

  assign valid_o    = vo_q;
  assign mapped_y_o = mapped_q;
  assign clipped_o  = clip_q;

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the piecewise linear curve block: loads knot sets, sweeps
// knot_count, streams queries and checks every mapped value against an in-bench predictor.
// Depends on hdl/plc_pkg.sv and hdl/piecewise_linear_curve.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plc_pkg::*;

  localparam int          CycleLimit   = 200000;
  localparam int          SettleCycles = 64;
  localparam int          PhaseBeats   = 80;
  localparam int          IdlePct      = 28;
  localparam logic [63:0] MaxVal       = (64'd1 << ValueBits) - 64'd1;

  typedef struct {
    opcode_e              op;
    logic [IdxBits-1:0]   idx;
    logic [ValueBits-1:0] kx;
    logic [ValueBits-1:0] ky;
    logic [ValueBits-1:0] qx;
  } curve_beat_t;

  typedef struct {
    logic [ValueBits-1:0] qx;
    logic [ValueBits-1:0] y;
    logic                 clip;
  } mapped_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic                 opcode_i     = OpEval;
  logic [IdxBits-1:0]   knot_index_i = '0;
  logic [ValueBits-1:0] knot_x_i     = '0;
  logic [ValueBits-1:0] knot_y_i     = '0;
  logic [ValueBits-1:0] query_x_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [ValueBits-1:0] mapped_y_o;
  logic                 clipped_o;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CountBits-1:0] knot_count_i = CountReset;

  // predictor state
  logic [ValueBits-1:0]        curve_x     [MaxKnots];
  logic [ValueBits-1:0]        curve_y     [MaxKnots];
  logic signed [SlopeBits-1:0] curve_slope [MaxKnots];
  logic [CountBits-1:0]        count_reg = CountReset;

  // stimulus planner's view of the knots
  logic [ValueBits-1:0] plan_x [MaxKnots];
  logic [ValueBits-1:0] plan_y [MaxKnots];
  bit   [MaxKnots-1:0]  knot_loaded = '0;

  curve_beat_t pending_beats [$];
  mapped_t     mapped_q [$];
  curve_beat_t cur_beat;
  int unsigned beats_queued = 0;
  int unsigned beats_taken  = 0;
  int unsigned cycle_count  = 0;
  int          error_count  = 0;
  int          idle_pct     = IdlePct;

  piecewise_linear_curve u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .knot_index_i (knot_index_i),
    .knot_x_i     (knot_x_i),
    .knot_y_i     (knot_y_i),
    .query_x_i    (query_x_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mapped_y_o   (mapped_y_o),
    .clipped_o    (clipped_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .knot_count_i (knot_count_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    for (int i = 0; i < MaxKnots; i++) begin
      curve_x[i]     = '0;
      curve_y[i]     = '0;
      curve_slope[i] = '0;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("%0t MISMATCH %s", $time, what);
    error_count++;
  endtask

  function automatic int eff_count(input logic [CountBits-1:0] v);
    if (v < CountMin) return int'(CountMin);
    if (v > CountMax) return int'(CountMax);
    return int'(v);
  endfunction

  // Signed Q17.16 slope of the segment (x0,y0)-(x1,y1), truncated toward zero
  function automatic logic signed [SlopeBits-1:0] slope_of_segment(
      input logic [ValueBits-1:0] x0, input logic [ValueBits-1:0] y0,
      input logic [ValueBits-1:0] x1, input logic [ValueBits-1:0] y1);
    logic [ValueBits-1:0] dy;
    logic [ValueBits-1:0] dx;
    logic [MagBits-1:0]   q;
    logic                 flip;
    dy = (y1 < y0) ? y0 - y1 : y1 - y0;
    dx = (x1 < x0) ? x0 - x1 : x1 - x0;
    if (dx == '0) return '0;
    q    = {dy, {SlopeFracBits{1'b0}}} / dx;
    flip = (y1 < y0) != (x1 < x0);
    return flip ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic mapped_t map_query(input logic [ValueBits-1:0] qx);
    int      n;
    int      seg;
    longint  d;
    longint  total;
    mapped_t m;
    n   = eff_count(count_reg);
    seg = 0;
    for (int i = 0; i + 1 < n; i++) begin
      if (curve_x[i] <= qx) seg = i;
    end
    d     = longint'(qx) - longint'(curve_x[seg]);
    total = (longint'(curve_y[seg]) <<< SlopeFracBits)
          + longint'(curve_slope[seg+1]) * d
          + (longint'(1) <<< (SlopeFracBits - 1));
    m.qx   = qx;
    m.clip = 1'b0;
    if (total < 0) begin
      m.y    = '0;
      m.clip = 1'b1;
    end else if ((total >>> SlopeFracBits) > longint'(MaxVal)) begin
      m.y    = '1;
      m.clip = 1'b1;
    end else begin
      m.y = ValueBits'(total >>> SlopeFracBits);
    end
    return m;
  endfunction

  function automatic void apply_beat(input curve_beat_t b);
    if (b.op == OpLoad) begin
      curve_x[b.idx] = b.kx;
      curve_y[b.idx] = b.ky;
      if (b.idx == '0) curve_slope[0] = '0;
      else curve_slope[b.idx] = slope_of_segment(curve_x[b.idx-1], curve_y[b.idx-1], b.kx, b.ky);
    end else begin
      mapped_q.push_back(map_query(b.qx));
    end
  endfunction

  function automatic void push_load(input int idx, input int x, input int y);
    curve_beat_t b;
    b.op  = OpLoad;
    b.idx = IdxBits'(idx);
    b.kx  = ValueBits'(x);
    b.ky  = ValueBits'(y);
    b.qx  = ValueBits'($urandom_range(0, 65535));
    pending_beats.push_back(b);
    beats_queued++;
    plan_x[b.idx]      = b.kx;
    plan_y[b.idx]      = b.ky;
    knot_loaded[b.idx] = 1'b1;
  endfunction

  function automatic void push_eval(input int qx);
    curve_beat_t b;
    b.op  = OpEval;
    b.idx = IdxBits'($urandom_range(0, MaxKnots - 1));
    b.kx  = ValueBits'($urandom_range(0, 65535));
    b.ky  = ValueBits'($urandom_range(0, 65535));
    b.qx  = ValueBits'(qx);
    pending_beats.push_back(b);
    beats_queued++;
  endfunction

  function automatic int pick_query(input int n);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 65535;
    // land on or just beside a knot
    if (r < 9) return int'(ValueBits'(plan_x[$urandom_range(0, n - 1)]
                                      + $urandom_range(0, 6) - 3));
    return $urandom_range(0, 65535);
  endfunction

  // Load a well-formed curve of n knots, then mix queries with knot reloads.
  task automatic fill_phase(input int n, input int count);
    int   step;
    int   idx;
    int   kx;
    bit   rising;
    step   = 65536 / n;
    rising = $urandom_range(0, 1);
    for (int j = 0; j < n; j++) begin
      push_load(j, j * step + $urandom_range(0, step - 1),
                rising ? j * step + $urandom_range(0, step - 1) : $urandom_range(0, 65535));
    end
    for (int j = 0; j < count; j++) begin
      if ($urandom_range(0, 99) < 12) begin
        do idx = $urandom_range(0, MaxKnots - 1);
        while (idx != 0 && !knot_loaded[idx-1]);
        case ($urandom_range(0, 2))
          0:       kx = $urandom_range(0, 65535);
          1:       kx = (idx == 0) ? $urandom_range(0, 65535) : int'(plan_x[idx-1]);
          default: kx = knot_loaded[idx] ? int'(ValueBits'(plan_x[idx] + $urandom_range(0, 15) - 8))
                                         : $urandom_range(0, 65535);
        endcase
        push_load(idx, kx, $urandom_range(0, 65535));
        // refresh the next segment's slope now and then
        if (idx < MaxKnots - 1 && knot_loaded[idx+1] && $urandom_range(0, 1))
          push_load(idx + 1, plan_x[idx+1], plan_y[idx+1]);
      end else begin
        push_eval(pick_query(n));
      end
    end
  endtask

  task automatic run_until_idle;
    do @(posedge clk_i);
    while (beats_taken != beats_queued || mapped_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_knot_count(input logic [CountBits-1:0] v);
    @(posedge clk_i);
    cfg_valid_i  <= 1'b1;
    knot_count_i <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    count_reg   = v;
  endtask

  // input driver: present the next pending beat once the current one is taken
  always @(posedge clk_i) begin
    curve_beat_t nb;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        apply_beat(cur_beat);
        beats_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nb           = pending_beats.pop_front();
          cur_beat     = nb;
          in_valid_i   <= 1'b1;
          opcode_i     <= nb.op;
          knot_index_i <= nb.idx;
          knot_x_i     <= nb.kx;
          knot_y_i     <= nb.ky;
          query_x_i    <= nb.qx;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    mapped_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (mapped_q.size() == 0) begin
          flag_mismatch($sformatf("result y=%h clip=%b with nothing outstanding",
                                  mapped_y_o, clipped_o));
        end else begin
          want = mapped_q.pop_front();
          if (mapped_y_o !== want.y)
            flag_mismatch($sformatf("qx=%h mapped_y got %h want %h",
                                    want.qx, mapped_y_o, want.y));
          if (clipped_o !== want.clip)
            flag_mismatch($sformatf("qx=%h clipped got %b want %b",
                                    want.qx, clipped_o, want.clip));
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [CountBits-1:0] count_plan [9];
    count_plan = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd17, 5'd9, 5'd0, 5'd0, 5'd2};
    count_plan[6] = CountBits'($urandom_range(3, 15));
    count_plan[7] = CountBits'($urandom_range(0, 31));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // two-knot curve at the reset count: extremes, ties, flat and reversed segments
    push_load(0, 'h1000, 'h0000);
    push_load(1, 'hF000, 'hFFFF);
    push_eval('h0000);
    push_eval('h1000);
    push_eval('h8000);
    push_eval('hFFFF);
    push_load(1, 'h1000, 'hFFFF);
    push_eval('h0000);
    push_eval('hFFFF);
    push_load(1, 'h0000, 'hFFFF);
    push_eval('h0000);
    push_eval('hFFFF);
    push_load(0, 'h0000, 'h0001);
    push_load(1, 'h0002, 'h0000);
    push_eval('h0001);
    push_eval('h0003);
    push_load(0, 'h0000, 'h0000);
    push_load(1, 'h0002, 'h0001);
    push_eval('h0001);
    push_eval('h0003);
    // steepest slope, then a stale slope after knot 0 moves
    push_load(0, 'h8000, 'h0000);
    push_load(1, 'h8001, 'hFFFF);
    push_eval('h0000);
    push_load(0, 'hFFFF, 'hFFFF);
    push_eval('h7FFF);
    run_until_idle();

    foreach (count_plan[p]) begin
      write_knot_count(count_plan[p]);
      idle_pct = (p == 4) ? 0 : IdlePct;
      fill_phase(eff_count(count_plan[p]), PhaseBeats);
      run_until_idle();
    end

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/plc_pkg.sv
hdl/plc_div.sv
hdl/plc_cell.sv
hdl/plc_eval.sv
hdl/piecewise_linear_curve.sv
dv/tb_top.sv
